FILE: hdl/cobs_frame_encoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the COBS frame encoder.
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef COBS_FRAME_ENCODER_ASSERT_SVH
`define COBS_FRAME_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cobs_frame_encoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cobs_frame_encoder: next-cycle check failed");

`endif

FILE: hdl/cfe_pkg.sv
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared constants, microcode types and the control store of the encoder.
// ----------------------------------------------------------------------------
package cfe_pkg;

   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned MAX_GROUP_DEFAULT = 60;

   localparam logic [BYTE_W-1:0] DELIM_BYTE     = 8'h00;
   localparam logic [BYTE_W-1:0] EMPTY_GRP_CODE = 8'h01;

   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_CODE  = 3'd1;
   localparam step_type STEP_DATA  = 3'd2;
   localparam step_type STEP_TAIL  = 3'd3;
   localparam step_type STEP_ONE   = 3'd4;
   localparam step_type STEP_DELIM = 3'd5;

   // What a step loads into the output register.
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_CODE,
      EMIT_DATA,
      EMIT_ONE,
      EMIT_DELIM
   } emit_type;

   // Branch condition; when true the sequencer jumps to the target,
   // otherwise it falls through to the next step.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_WORK,
      COND_NO_BYTES,
      COND_MORE_BYTES,
      COND_NOT_LAST
   } cond_type;

   typedef struct packed {
      emit_type emit;
      cond_type cond;
      step_type target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      unique case (step)
         STEP_IDLE:  word = '{emit: EMIT_NONE,  cond: COND_NO_WORK,    target: STEP_IDLE};
         STEP_CODE:  word = '{emit: EMIT_CODE,  cond: COND_NO_BYTES,   target: STEP_TAIL};
         STEP_DATA:  word = '{emit: EMIT_DATA,  cond: COND_MORE_BYTES, target: STEP_DATA};
         STEP_TAIL:  word = '{emit: EMIT_NONE,  cond: COND_NOT_LAST,   target: STEP_IDLE};
         STEP_ONE:   word = '{emit: EMIT_ONE,   cond: COND_NEVER,      target: STEP_IDLE};
         STEP_DELIM: word = '{emit: EMIT_DELIM, cond: COND_ALWAYS,     target: STEP_IDLE};
         default:    word = '{emit: EMIT_NONE,  cond: COND_ALWAYS,     target: STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

FILE: hdl/cfe_req_if.sv
// ----------------------------------------------------------------------------
// cfe_req_if
// Request channel: one payload byte and its end-of-packet flag.
// ----------------------------------------------------------------------------
interface cfe_req_if;
   import cfe_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_in;

   modport source (output valid, output data_byte, output last_in, input ready);
   modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

FILE: hdl/cfe_rsp_if.sv
// ----------------------------------------------------------------------------
// cfe_rsp_if
// Response channel: one encoded byte with its framing flags.
// ----------------------------------------------------------------------------
interface cfe_rsp_if;
   import cfe_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              run_last;
   logic              frame_end;

   modport source (output valid, output out_byte, output run_last, output frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input frame_end,
                   output ready);
endinterface

FILE: hdl/cobs_frame_encoder.sv
// ----------------------------------------------------------------------------
// cobs_frame_encoder
// COBS-style framing of packet bytes, run by a small microcoded sequencer.
// Requests are accepted at the idle step; the step register then moves to the
// code step, which loads the output register. A byte that only buffers leaves
// the sequencer idle; a flush holds the input through the code, data and tail
// steps; at packet end also the empty-group step (silent for a non-zero byte)
// and delimiter step; output runs one byte a cycle unless the response stalls.
// Reset (synchronous, active high) empties the group and idles the sequencer.
// ----------------------------------------------------------------------------
`include "cobs_frame_encoder_assert.svh"

module cobs_frame_encoder #(
   parameter int unsigned MAX_GROUP = cfe_pkg::MAX_GROUP_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   cfe_req_if.sink   req_ch,
   cfe_rsp_if.source rsp_ch
);
   import cfe_pkg::*;

   // The group count must reach MAX_GROUP; the memory address only needs
   // to reach MAX_GROUP - 1, with at least one bit.
   localparam int unsigned CNT_W  = $clog2(MAX_GROUP + 1);
   localparam int unsigned ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int unsigned DEPTH  = 1 << ADDR_W;

   localparam logic [BYTE_W-1:0] CODE_FULL = BYTE_W'(MAX_GROUP + 1);

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   // Sequencer step counter; the program lives in cfe_pkg::ucode_rom.
   step_type          step_ff,  step_in;
   // Bytes held in the currently open group (always below MAX_GROUP).
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   // Per-request context captured at acceptance.
   logic [CNT_W-1:0]  len_ff,   len_in;   // held bytes to send after the code
   logic [BYTE_W-1:0] code_ff,  code_in;  // code byte of the closed group
   logic              last_ff,  last_in;  // request ended the packet
   logic              zero_ff,  zero_in;  // request byte was zero
   // Read index into the group memory while data bytes are sent.
   logic [CNT_W-1:0]  idx_ff,   idx_in;
   // Output register toward the response channel.
   logic              ovld_ff,  ovld_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   logic              olast_ff, olast_in;
   logic              oend_ff,  oend_in;

   // Group memory with a registered read port.
   logic [BYTE_W-1:0] grp_mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // ------------------------------------------------------------------------
   // Control word and decode
   // ------------------------------------------------------------------------
   ucode_type         uword;
   logic              accept;
   logic              byte_is_zero;
   logic [CNT_W-1:0]  cnt_inc;
   logic              grp_full;
   logic              has_work;
   logic              emit_active;
   logic              load;
   logic              cond_true;
   logic [CNT_W:0]    idx_next;
   logic              idx_at_end;

   assign uword  = ucode_rom(step_ff);

   // Requests are taken only at the idle step; one request at a time.
   assign req_ch.ready = (step_ff == STEP_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign byte_is_zero = (req_ch.data_byte == '0);
   assign cnt_inc      = cnt_ff + CNT_W'(1);
   assign grp_full     = !byte_is_zero && (cnt_inc == CNT_W'(MAX_GROUP));

   // A non-zero, non-final byte that leaves room in the group only buffers.
   assign has_work = byte_is_zero || req_ch.last_in || grp_full;

   assign idx_next   = {1'b0, idx_ff} + (CNT_W + 1)'(1);
   assign idx_at_end = (idx_next == {1'b0, len_ff});

   // The empty-group code after a zero final byte is only sent for a zero.
   assign emit_active = (uword.emit != EMIT_NONE) && !((uword.emit == EMIT_ONE) && !zero_ff);

   // The output register is free when empty or being drained this cycle.
   assign load = emit_active && (!ovld_ff || rsp_ch.ready);

   always_comb begin
      case (uword.cond)
         COND_NEVER:      cond_true = 1'b0;
         COND_ALWAYS:     cond_true = 1'b1;
         COND_NO_WORK:    cond_true = !(accept && has_work);
         COND_NO_BYTES:   cond_true = (len_ff == '0);
         COND_MORE_BYTES: cond_true = !idx_at_end;
         COND_NOT_LAST:   cond_true = !last_ff;
         default:         cond_true = 1'b1;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer: a step that must emit holds while the output is blocked.
   // ------------------------------------------------------------------------
   always_comb begin
      if (emit_active && !load) begin
         step_in = step_ff;
      end else if (cond_true) begin
         step_in = uword.target;
      end else begin
         step_in = step_ff + step_type'(1);
      end
   end

   // ------------------------------------------------------------------------
   // Request capture: group bookkeeping and the context of the flush.
   // ------------------------------------------------------------------------
   always_comb begin
      cnt_in  = cnt_ff;
      len_in  = len_ff;
      code_in = code_ff;
      last_in = last_ff;
      zero_in = zero_ff;
      if (accept) begin
         last_in = req_ch.last_in;
         zero_in = byte_is_zero;
         if (byte_is_zero) begin
            // A zero closes the group; its code counts the implied zero.
            code_in = BYTE_W'(cnt_ff) + BYTE_W'(1);
            len_in  = cnt_ff;
            cnt_in  = '0;
         end else if (grp_full) begin
            // A full group is sent with the maximum code and no implied zero.
            code_in = CODE_FULL;
            len_in  = cnt_inc;
            cnt_in  = '0;
         end else if (req_ch.last_in) begin
            code_in = BYTE_W'(cnt_inc) + BYTE_W'(1);
            len_in  = cnt_inc;
            cnt_in  = '0;
         end else begin
            cnt_in  = cnt_inc;
         end
      end
   end

   // The read index is fed ahead, so rd_data_ff always holds the byte at
   // idx_ff by the time a data step runs.
   always_comb begin
      if (accept) begin
         idx_in = '0;
      end else if (load && (uword.emit == EMIT_DATA)) begin
         idx_in = idx_next[CNT_W-1:0];
      end else begin
         idx_in = idx_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------------
   always_comb begin
      ovld_in  = ovld_ff && !rsp_ch.ready;
      obyte_in = obyte_ff;
      olast_in = olast_ff;
      oend_in  = oend_ff;
      if (load) begin
         ovld_in = 1'b1;
         case (uword.emit)
            EMIT_CODE: begin
               // Last response when no bytes and no frame tail follow.
               obyte_in = code_ff;
               olast_in = (len_ff == '0) && !last_ff;
               oend_in  = 1'b0;
            end
            EMIT_DATA: begin
               obyte_in = rd_data_ff;
               olast_in = idx_at_end && !last_ff;
               oend_in  = 1'b0;
            end
            EMIT_ONE: begin
               // The delimiter always follows the trailing empty group.
               obyte_in = EMPTY_GRP_CODE;
               olast_in = 1'b0;
               oend_in  = 1'b0;
            end
            EMIT_DELIM: begin
               obyte_in = DELIM_BYTE;
               olast_in = 1'b1;
               oend_in  = 1'b1;
            end
            default: begin
               obyte_in = obyte_ff;
               olast_in = olast_ff;
               oend_in  = oend_ff;
            end
         endcase
      end
   end

   assign rsp_ch.valid     = ovld_ff;
   assign rsp_ch.out_byte  = obyte_ff;
   assign rsp_ch.run_last  = olast_ff;
   assign rsp_ch.frame_end = oend_ff;

   // ------------------------------------------------------------------------
   // State registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         cnt_ff  <= '0;
         idx_ff  <= '0;
         ovld_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
         idx_ff  <= idx_in;
         ovld_ff <= ovld_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      code_ff  <= code_in;
      last_ff  <= last_in;
      zero_ff  <= zero_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
      oend_ff  <= oend_in;
   end

   // Group memory: every non-zero request byte is written at the fill
   // position; a read of the old value at that address in the same cycle
   // is harmless because the code byte always goes out first.
   always_ff @(posedge clock) begin
      if (accept && !byte_is_zero) begin
         grp_mem[cnt_ff[ADDR_W-1:0]] <= req_ch.data_byte;
      end
      rd_data_ff <= grp_mem[idx_in[ADDR_W-1:0]];
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `CFE_ASSERT_NOW(a_cnt_below_max, clock, reset, 1'b1, cnt_ff < CNT_W'(MAX_GROUP))
   `CFE_ASSERT_NOW(a_data_in_group, clock, reset, step_ff == STEP_DATA, idx_ff < len_ff)
   `CFE_ASSERT_NOW(a_end_is_delim, clock, reset, ovld_ff && oend_ff, olast_ff && (obyte_ff == DELIM_BYTE))
   `CFE_ASSERT_NOW(a_idle_no_emit, clock, reset, step_ff == STEP_IDLE, !load)
   `CFE_ASSERT_NEXT(a_delim_to_idle, clock, reset, load && (uword.emit == EMIT_DELIM), step_ff == STEP_IDLE)

endmodule

FILE: bench/cfe_frame_checker.sv
// ----------------------------------------------------------------------------
// cfe_frame_checker
// Watches the request and response channels of the COBS frame encoder. It
// keeps its own copy of the group buffer, works out the encoded bytes that
// each accepted request must produce, and compares every accepted response
// byte against the oldest one still due.
// ----------------------------------------------------------------------------
module cfe_frame_checker #(
   parameter int unsigned GROUP_MAX = cfe_pkg::MAX_GROUP_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cfe_req_if          req_mon,
   cfe_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned bytes_due,
   output int unsigned bytes_checked,
   output int unsigned frames_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import cfe_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              frame_end;
   } coded_byte_type;

   logic [BYTE_W-1:0] held_bytes [GROUP_MAX];
   int unsigned       held_len;
   coded_byte_type    coded_due [$];

   task automatic push_coded(input logic [BYTE_W-1:0] value, input logic is_delim);
      coded_due.push_back('{out_byte: value, run_last: 1'b0, frame_end: is_delim});
   endtask

   // Emits a code byte followed by every held byte, then empties the group.
   task automatic flush_group(input logic [BYTE_W-1:0] code);
      push_coded(code, 1'b0);
      for (int unsigned i = 0; i < held_len; i++) begin
         push_coded(held_bytes[i], 1'b0);
      end
      held_len = 0;
   endtask

   task automatic encode_request(input logic [BYTE_W-1:0] payload, input logic last);
      int unsigned first_new;
      first_new = coded_due.size();
      if (payload == DELIM_BYTE) begin
         // A zero closes the group; as the last byte it also opens an
         // empty final group before the delimiter.
         flush_group(BYTE_W'(held_len + 1));
         if (last) begin
            push_coded(EMPTY_GRP_CODE, 1'b0);
            push_coded(DELIM_BYTE, 1'b1);
         end
      end else begin
         held_bytes[held_len] = payload;
         held_len++;
         if (held_len == GROUP_MAX) begin
            // A full group goes out with no implied zero. If the packet ends
            // here, only the delimiter follows.
            flush_group(BYTE_W'(GROUP_MAX + 1));
            if (last) begin
               push_coded(DELIM_BYTE, 1'b1);
            end
         end else if (last) begin
            flush_group(BYTE_W'(held_len + 1));
            push_coded(DELIM_BYTE, 1'b1);
         end
      end
      if (coded_due.size() > first_new) begin
         coded_due[coded_due.size() - 1].run_last = 1'b1;
      end
   endtask

   task automatic note_failure(input string msg);
      if (mismatch_count < 10) begin
         $display("[%0t] %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      bytes_due      = 0;
      bytes_checked  = 0;
      frames_checked = 0;
      held_len       = 0;
   end

   always @(posedge clock) begin
      coded_byte_type seen;
      coded_byte_type wanted;
      if (reset) begin
         held_len = 0;
         coded_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            encode_request(req_mon.data_byte, req_mon.last_in);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{out_byte: rsp_mon.out_byte, run_last: rsp_mon.run_last,
                     frame_end: rsp_mon.frame_end};
            if (coded_due.size() == 0) begin
               note_failure($sformatf("unexpected response: out_byte %02h run_last %b frame_end %b",
                                      seen.out_byte, seen.run_last, seen.frame_end));
            end else begin
               wanted = coded_due.pop_front();
               if (seen.out_byte !== wanted.out_byte || seen.run_last !== wanted.run_last ||
                   seen.frame_end !== wanted.frame_end) begin
                  note_failure($sformatf({"response %0d: expected out_byte %02h run_last %b ",
                                          "frame_end %b, got out_byte %02h run_last %b ",
                                          "frame_end %b"},
                                         bytes_checked, wanted.out_byte, wanted.run_last,
                                         wanted.frame_end, seen.out_byte, seen.run_last,
                                         seen.frame_end));
               end
               bytes_checked++;
               if (wanted.frame_end) begin
                  frames_checked++;
               end
            end
         end
      end
      bytes_due = coded_due.size();
   end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the COBS frame encoder bench. Sends a few hand-picked packets that
// hit the corner cases of the framing, then a few hundred payload bytes in
// packets of random shape, with random gaps on the request side and random
// stalls on the response side. The checker beside the block does all the
// comparing; this module makes the traffic and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfe_pkg::*;

   localparam int unsigned GROUP_MAX    = MAX_GROUP_DEFAULT;
   localparam int unsigned RANDOM_BYTES = 400;
   // A request sends at most a full group plus its code and framing bytes, so
   // the quiet stretch at the end lets any stray byte show up.
   localparam int unsigned DRAIN_CYCLES = GROUP_MAX + 20;

   // Shapes of random packets. Short and zero-heavy ones give many frame
   // ends; full and long ones drive the group to its size limit.
   typedef enum int {
      SHAPE_SHORT,
      SHAPE_ZEROS,
      SHAPE_MIXED,
      SHAPE_FULL,
      SHAPE_LONG
   } packet_shape_type;

   logic clock = 1'b0;
   logic reset;

   int unsigned mismatch_count;
   int unsigned bytes_due;
   int unsigned bytes_checked;
   int unsigned frames_checked;

   // Upper bounds of the per-request gap and per-response stall; the
   // stimulus switches them to zero now and then for back-to-back stretches.
   int unsigned req_gap_max   = 8;
   int unsigned rsp_stall_max = 8;
   int unsigned bytes_sent    = 0;
   int unsigned packets_sent  = 0;

   cfe_req_if req_bus ();
   cfe_rsp_if rsp_bus ();

   cobs_frame_encoder #(.MAX_GROUP(GROUP_MAX)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   cfe_frame_checker #(.GROUP_MAX(GROUP_MAX)) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .bytes_due      (bytes_due),
      .bytes_checked  (bytes_checked),
      .frames_checked (frames_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offers one payload byte after a random gap and holds it until accepted.
   // It is entered and left just after a falling edge. When the gap is zero,
   // valid simply stays high into the next request.
   task automatic send_byte(input logic [BYTE_W-1:0] payload, input logic last);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= payload;
      req_bus.last_in   <= last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      bytes_sent++;
      if (last) begin
         packets_sent++;
      end
   endtask

   // Builds one packet of the given shape. Non-zero bytes span the whole
   // range 1..255 so every bit of the payload toggles.
   task automatic send_packet(input packet_shape_type shape);
      int unsigned       len;
      int unsigned       zero_pct;
      logic [BYTE_W-1:0] payload;
      case (shape)
         SHAPE_SHORT: begin
            len      = $urandom_range(1, 8);
            zero_pct = 30;
         end
         SHAPE_ZEROS: begin
            len      = $urandom_range(1, 12);
            zero_pct = 70;
         end
         SHAPE_MIXED: begin
            len      = $urandom_range(9, 40);
            zero_pct = 10;
         end
         SHAPE_FULL: begin
            len      = GROUP_MAX;
            zero_pct = 0;
         end
         default: begin
            len      = $urandom_range(GROUP_MAX + 1, 2 * GROUP_MAX + 5);
            zero_pct = 2;
         end
      endcase
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < zero_pct) begin
            payload = DELIM_BYTE;
         end else begin
            payload = BYTE_W'($urandom_range(1, 255));
         end
         // Half of the full-length packets end on a zero, which leaves one
         // byte short of a full group and then closes it.
         if (shape == SHAPE_FULL && i == len - 1 && $urandom_range(0, 1) == 1) begin
            payload = DELIM_BYTE;
         end
         send_byte(payload, i == len - 1);
      end
   endtask

   // Response side: a random stall before each byte, then ready stays high
   // until one byte has been taken.
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   initial begin
      int unsigned      random_start;
      int unsigned      random_pkts;
      int unsigned      pick;
      packet_shape_type shape;

      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_in   = 1'b0;
      reset             = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A lone zero: an empty group closed by the zero, then an empty
      // final group and the delimiter.
      send_byte(8'h00, 1'b1);
      // A lone byte at each end of the non-zero range.
      send_byte(8'hFF, 1'b1);
      send_byte(8'h01, 1'b1);
      // A zero in the middle of a packet splits it into two groups.
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      // Two zeros in a row, the second being the last byte.
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // Data and then a zero as the last byte.
      send_byte(8'h12, 1'b0);
      send_byte(8'h00, 1'b1);
      // Back-to-back traffic with no gaps or stalls on either side.
      req_gap_max   = 0;
      rsp_stall_max = 0;
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFE, 1'b1);

      // Random part. The first packet is a full group long and the second runs
      // well past it, both aimed at the group limit.
      random_start = bytes_sent;
      random_pkts  = packets_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
         if (bytes_sent == random_start) begin
            shape = SHAPE_FULL;
         end else if (packets_sent == random_pkts + 1) begin
            shape = SHAPE_LONG;
         end else begin
            pick = $urandom_range(0, 15);
            if (pick <= 6) begin
               shape = SHAPE_SHORT;
            end else if (pick <= 10) begin
               shape = SHAPE_ZEROS;
            end else if (pick <= 12 || pick == 15) begin
               shape = SHAPE_MIXED;
            end else if (pick == 13) begin
               shape = SHAPE_FULL;
            end else begin
               shape = SHAPE_LONG;
            end
         end
         send_packet(shape);
      end
      req_bus.valid <= 1'b0;

      // Wait for every predicted byte, then give the block time to emit
      // anything it should not.
      while (bytes_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d payload bytes in %0d packets (group limit %0d).",
               bytes_sent, packets_sent, GROUP_MAX);
      $display("Checked %0d encoded bytes over %0d frames; %0d disagreed.",
               bytes_checked, frames_checked, mismatch_count);
      if (mismatch_count == 0 && bytes_due == 0) begin
         $display("cobs_frame_encoder: match");
      end else begin
         $display("cobs_frame_encoder: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #50_000_000;
      $display("Timed out with %0d encoded bytes still due.", bytes_due);
      $display("cobs_frame_encoder: mismatch");
      $finish;
   end

endmodule

FILE: cobs_frame_encoder.f
+incdir+hdl
hdl/cfe_pkg.sv
hdl/cfe_req_if.sv
hdl/cfe_rsp_if.sv
hdl/cobs_frame_encoder.sv
bench/cfe_frame_checker.sv
bench/tb.sv
